/* hdl/spcp_pkg.sv */
// shared types, character codes and keyword tables for the serial pwm command parser
// no dependencies; imported by the scan unit and top level
`default_nettype none

package spcp_pkg;

    // control characters and punctuation
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    // highest duty value a command may set
    localparam logic [10:0] DUTY_MAX = 11'd100;

    // response codes
    localparam logic [1:0] KIND_OK     = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // sequencer to scan unit
    typedef struct packed {
        logic start;
        logic step;
    } scan_ctrl_t;

    // scan unit verdict once the whole line has been walked
    typedef struct packed {
        logic       on_match;
        logic       off_match;
        logic       status_match;
        logic       pwm_ok;
        logic [6:0] pwm_value;
    } scan_result_t;

    // keyword characters by position
    function automatic logic [7:0] on_char(input logic pos);
        logic [7:0] c;
        c = pos ? 8'h4E : 8'h4F;           // "ON"
        return c;
    endfunction

    function automatic logic [7:0] off_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h4F;            // 'O'
            2'd1:    c = 8'h46;            // 'F'
            2'd2:    c = 8'h46;            // 'F'
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] status_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h53;            // 'S'
            3'd1:    c = 8'h74;            // 't'
            3'd2:    c = 8'h61;            // 'a'
            3'd3:    c = 8'h74;            // 't'
            3'd4:    c = 8'h75;            // 'u'
            3'd5:    c = 8'h73;            // 's'
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pwm_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h50;            // 'P'
            2'd1:    c = 8'h57;            // 'W'
            2'd2:    c = 8'h4D;            // 'M'
            2'd3:    c = 8'h3A;            // ':'
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/serial_pwm_command_parser.sv */
// Serial PWM command parser. Each received byte is one input item. Ordinary
// bytes, backspace, DEL, CR and LF leave the parser idle. A '!' on a non-empty
// line that did not overflow walks the stored line one character per cycle
// through a shared checker fed by the single read port of the line memory; no
// item is accepted meanwhile. Results wait in an output register, and the next
// byte is taken as soon as that register is empty or being emptied in the same
// cycle.
// depends on spcp_pkg, spcp_line_mem and spcp_scan_unit
`default_nettype none

module serial_pwm_command_parser #(
    parameter int LINE_DEPTH = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] duty_percent, [7] output_enabled
    output logic [1:0]      m_tuser    // [1:0] response_kind
);

    import spcp_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] count_reg, count_next;
    logic          ovf_reg,   ovf_next;
    logic [6:0]    duty_reg,  duty_next;
    logic          drive_reg, drive_next;
    logic [AW-1:0] idx_reg,   idx_next;

    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg,  m_tdata_next;
    logic [1:0]    m_tuser_reg,  m_tuser_next;

    logic          s_accept;
    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    scan_ctrl_t    scan_ctrl;
    scan_result_t  scan_result;

    // handshake
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    // line memory: read the next character ahead of the scan step
    assign rd_addr = (state_reg == ST_SCAN) ? AW'(idx_reg + AW'(1)) : '0;

    spcp_line_mem #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    spcp_scan_unit #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_scan (
        .aclk   (aclk),
        .ctrl   (scan_ctrl),
        .idx    (idx_reg),
        .count  (count_reg),
        .ch     (rd_data),
        .result (scan_result)
    );

    // sequencer and line bookkeeping
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        duty_next       = duty_reg;
        drive_next      = drive_reg;
        idx_next        = idx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        wr_en           = 1'b0;
        scan_ctrl.start = 1'b0;
        scan_ctrl.step  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tdata == CH_BANG) begin
                        ovf_next = 1'b0;
                        if ((count_reg != '0) && !ovf_reg) begin
                            // count is kept for the walk and cleared at the end
                            scan_ctrl.start = 1'b1;
                            idx_next        = '0;
                            state_next      = ST_SCAN;
                        end else begin
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = KIND_ERROR;
                            m_tdata_next  = '0;
                            count_next    = '0;
                        end
                    end else if ((s_tdata == CH_CR) || (s_tdata == CH_LF)) begin
                        if ((count_reg != '0) || ovf_reg) begin
                            m_tvalid_next = 1'b1;
                            m_tuser_next  = KIND_ERROR;
                            m_tdata_next  = '0;
                        end
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else if ((s_tdata == CH_BS) || (s_tdata == CH_DEL)) begin
                        if (count_reg != '0) begin
                            count_next = AW'(count_reg - AW'(1));
                        end
                    end else if (!ovf_reg && (count_reg != AW'(LINE_DEPTH - 1))) begin
                        wr_en      = 1'b1;
                        count_next = AW'(count_reg + AW'(1));
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // one stored character per cycle
                scan_ctrl.step = 1'b1;
                idx_next       = AW'(idx_reg + AW'(1));
                if (idx_reg == AW'(count_reg - AW'(1))) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // commands in priority order
                m_tvalid_next = 1'b1;
                m_tuser_next  = KIND_OK;
                if (scan_result.on_match) begin
                    drive_next = 1'b1;
                end else if (scan_result.off_match) begin
                    drive_next = 1'b0;
                end else if (scan_result.status_match) begin
                    m_tuser_next = KIND_STATUS;
                end else if (scan_result.pwm_ok) begin
                    duty_next = scan_result.pwm_value;
                end else begin
                    m_tuser_next = KIND_ERROR;
                end
                if (m_tuser_next == KIND_ERROR) begin
                    m_tdata_next = '0;
                end else begin
                    m_tdata_next = {drive_next, duty_next};
                end
                count_next = '0;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            duty_reg     <= '0;
            drive_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            duty_reg     <= duty_next;
            drive_reg    <= drive_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // output register stays empty while a line is walked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !m_tvalid_reg)
        else $error("result pending during line scan");

    // an error result carries no duty or enable
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tuser_reg == KIND_ERROR)) |-> (m_tdata_reg == '0))
        else $error("error result with nonzero payload");

    // finishing a command returns to idle with an empty line and a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> ((state_reg == ST_IDLE) && (count_reg == '0)
                                    && m_tvalid_reg))
        else $error("command finish did not clear the line");

    // the line never grows past its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= AW'(LINE_DEPTH - 1))
        else $error("line count beyond capacity");

    // duty stays in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        duty_reg <= 7'd100)
        else $error("duty above 100");

endmodule

`default_nettype wire

/* hdl/spcp_line_mem.sv */
// line store of the command parser: one write port, one registered read port
// uses no package items
`default_nettype none

module spcp_line_mem #(
    parameter  int LINE_DEPTH = 32,
    localparam int AW         = $clog2(LINE_DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/spcp_scan_unit.sv */
// shared character checker: one stored character per step against all command forms
// depends on spcp_pkg for keyword tables and the control and result structs
`default_nettype none

module spcp_scan_unit #(
    parameter  int LINE_DEPTH = 32,
    localparam int AW         = $clog2(LINE_DEPTH)
) (
    input  wire logic                 aclk,
    input  wire spcp_pkg::scan_ctrl_t ctrl,
    input  wire logic [AW-1:0]        idx,
    input  wire logic [AW-1:0]        count,
    input  wire logic [7:0]           ch,
    output spcp_pkg::scan_result_t    result
);

    import spcp_pkg::*;

    logic          zero_found_reg, zero_found_next;
    logic [AW-1:0] zero_pos_reg,   zero_pos_next;
    logic          on_reg,         on_next;
    logic          off_reg,        off_next;
    logic          status_reg,     status_next;
    logic          pwm_reg,        pwm_next;
    logic [6:0]    value_reg,      value_next;

    logic          is_digit;
    logic [10:0]   prod;
    logic          last;
    logic [AW-1:0] text_len;

    // digit accumulate: value * 10 + digit
    assign is_digit = (ch >= CH_0) && (ch <= CH_9);
    assign prod     = (11'(value_reg) << 3) + (11'(value_reg) << 1)
                    + 11'(ch[3:0]);
    assign last     = (idx == AW'(count - AW'(1)));

    // one step of every check
    always_comb begin
        zero_found_next = zero_found_reg;
        zero_pos_next   = zero_pos_reg;
        on_next         = on_reg;
        off_next        = off_reg;
        status_next     = status_reg;
        pwm_next        = pwm_reg;
        value_next      = value_reg;
        if (ctrl.start) begin
            zero_found_next = 1'b0;
            zero_pos_next   = '0;
            on_next         = 1'b1;
            off_next        = 1'b1;
            status_next     = 1'b1;
            pwm_next        = (count >= AW'(6));
            value_next      = '0;
        end else if (ctrl.step) begin
            // first zero byte ends the keyword text
            if ((ch == CH_NUL) && !zero_found_reg) begin
                zero_found_next = 1'b1;
                zero_pos_next   = idx;
            end
            // keyword prefixes
            if ((idx < AW'(2)) && (ch != on_char(idx[0]))) begin
                on_next = 1'b0;
            end
            if ((idx < AW'(3)) && (ch != off_char(idx[1:0]))) begin
                off_next = 1'b0;
            end
            if ((idx < AW'(6)) && (ch != status_char(idx[2:0]))) begin
                status_next = 1'b0;
            end
            // pwm form: prefix, digits, closing percent sign
            if (idx < AW'(4)) begin
                if (ch != pwm_char(idx[1:0])) begin
                    pwm_next = 1'b0;
                end
            end else if (last) begin
                if (ch != CH_PCT) begin
                    pwm_next = 1'b0;
                end
            end else begin
                if (!is_digit || (prod > DUTY_MAX)) begin
                    pwm_next = 1'b0;
                end
                value_next = prod[6:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        zero_found_reg <= zero_found_next;
        zero_pos_reg   <= zero_pos_next;
        on_reg         <= on_next;
        off_reg        <= off_next;
        status_reg     <= status_next;
        pwm_reg        <= pwm_next;
        value_reg      <= value_next;
    end

    // verdict: keyword prefix matched and the text is exactly that long
    assign text_len = zero_found_reg ? zero_pos_reg : count;

    always_comb begin
        result.on_match     = on_reg     && (text_len == AW'(2));
        result.off_match    = off_reg    && (text_len == AW'(3));
        result.status_match = status_reg && (text_len == AW'(6));
        result.pwm_ok       = pwm_reg;
        result.pwm_value    = value_reg;
    end

endmodule

`default_nettype wire
